### rtl/lpnm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpnm_pkg
// Shared types and constants for the length-prefixed name multi-matcher.
// ----------------------------------------------------------------------------
package lpnm_pkg;

  localparam int FOUND_W = 16;
  localparam int SLOT_W  = 4;
  localparam int CHAR_W  = 6;
  localparam int BYTE_W  = 8;
  localparam int ACT_W   = 5;
  localparam int PRE_W   = 4;

  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SCAN   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  localparam logic KIND_DEFINE = 1'b0;
  localparam logic KIND_FOUND  = 1'b1;
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_REFUSED  = 1'b1;

  typedef struct packed {
    logic                define_en;
    logic                define_ok;
    logic                load_en;
    logic                scan_en;
    logic                end_en;
    logic [SLOT_W-1:0]   slot;
    logic [CHAR_W-1:0]   char_index;
    logic [BYTE_W-1:0]   value;
    logic [BYTE_W-1:0]   name_length;
    logic [ACT_W-1:0]    active_patterns;
  } slot_ctrl_t;

  typedef struct packed {
    logic                clear;
    logic                step;
    logic                define_wr;
    logic                load_wr;
    logic [CHAR_W-1:0]   char_index;
    logic [BYTE_W-1:0]   value;
    logic [BYTE_W-1:0]   name_length;
  } cell_ctrl_t;

  typedef struct packed {
    logic                report_kind;
    logic                define_status;
    logic [FOUND_W-1:0]  found_mask;
  } result_t;

endpackage
`default_nettype wire

### rtl/lpnm_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpnm channel interfaces
// Valid/ready channels for configuration, input items and reports.
// ----------------------------------------------------------------------------
interface lpnm_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpnm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] slot;
  logic [5:0] char_index;
  logic [7:0] value;
  logic [7:0] name_length;
  modport source (output valid, output operation, output slot, output char_index,
                  output value, output name_length, input ready);
  modport sink   (input valid, input operation, input slot, input char_index,
                  input value, input name_length, output ready);
endinterface

interface lpnm_report_if;
  logic        valid;
  logic        ready;
  logic        report_kind;
  logic        define_status;
  logic [15:0] found_mask;
  modport source (output valid, output report_kind, output define_status,
                  output found_mask, input ready);
  modport sink   (input valid, input report_kind, input define_status,
                  input found_mask, output ready);
endinterface
`default_nettype wire

### rtl/lpnm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpnm_cell
// One name-character position: stored byte plus shift-and match bit.
// ----------------------------------------------------------------------------
module lpnm_cell import lpnm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       prev_match,
  output logic       match,
  output logic       term
);

  logic [BYTE_W-1:0] name_byte;
  logic              en;
  logic              last;
  logic              match_next;

  always_ff @(posedge clk) begin
    if (ctrl.load_wr && (BYTE_W'(ctrl.char_index) == BYTE_W'(IDX))) begin
      name_byte <= ctrl.value;
    end
    if (ctrl.define_wr) begin
      en   <= BYTE_W'(IDX) < ctrl.name_length;
      last <= BYTE_W'(IDX + 1) == ctrl.name_length;
    end
  end

  always_comb begin
    match_next = match;
    if (ctrl.clear) begin
      match_next = 1'b0;
    end else if (ctrl.step) begin
      match_next = en && prev_match && (name_byte == ctrl.value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      match <= match_next;
    end
  end

  assign term = match & last;

endmodule
`default_nettype wire

### rtl/lpnm_slot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpnm_slot
// One pattern slot: length prefix stage followed by a row of name cells.
// ----------------------------------------------------------------------------
module lpnm_slot import lpnm_pkg::*; #(
  parameter int NAME_CHARS = 64,
  parameter int SLOT_IDX   = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  slot_ctrl_t ctrl,
  output logic       hit,
  output logic       valid
);

  logic                  sel;
  logic                  active;
  logic                  step;
  logic                  clear;
  logic [BYTE_W-1:0]     slen;
  logic [BYTE_W-1:0]     prefix;
  logic [PRE_W-1:0]      pre;
  logic [PRE_W-1:0]      pre_next;
  logic [NAME_CHARS-1:0] match;
  logic [NAME_CHARS-1:0] term;
  logic [NAME_CHARS:0]   chain;
  cell_ctrl_t            cctrl;

  assign sel    = ctrl.slot == SLOT_W'(SLOT_IDX);
  assign active = ctrl.active_patterns > ACT_W'(SLOT_IDX);
  assign step   = ctrl.scan_en && active && valid;
  assign clear  = ctrl.end_en || (ctrl.define_en && sel) ||
                  (ctrl.scan_en && !(active && valid));
  assign prefix = slen + BYTE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.define_en && sel) begin
      valid <= ctrl.define_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.define_en && sel && ctrl.define_ok) begin
      slen <= ctrl.name_length;
    end
  end

  // little-endian 32-bit length+1, upper bytes always zero
  always_comb begin
    pre_next[0] = ctrl.value == prefix;
    pre_next[1] = pre[0] && (ctrl.value == '0);
    pre_next[2] = pre[1] && (ctrl.value == '0);
    pre_next[3] = pre[2] && (ctrl.value == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre <= '0;
    end else if (clear) begin
      pre <= '0;
    end else if (step) begin
      pre <= pre_next;
    end
  end

  always_comb begin
    cctrl.clear       = clear;
    cctrl.step        = step;
    cctrl.define_wr   = ctrl.define_en && sel && ctrl.define_ok;
    cctrl.load_wr     = ctrl.load_en && sel;
    cctrl.char_index  = ctrl.char_index;
    cctrl.value       = ctrl.value;
    cctrl.name_length = ctrl.name_length;
  end

  assign chain[0] = pre[PRE_W-1];

  for (genvar i = 0; i < NAME_CHARS; i++) begin : g_cell
    lpnm_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cctrl),
      .prev_match (chain[i]),
      .match      (match[i]),
      .term       (term[i])
    );
    assign chain[i+1] = match[i];
  end

  // terminator byte completes the pattern
  assign hit = step && (ctrl.value == '0) &&
               ((slen == '0) ? pre[PRE_W-1] : (|term));

endmodule
`default_nettype wire

### rtl/length_prefixed_name_multi_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_name_multi_matcher
// Shift-and matcher over length-prefixed names, one cell per pattern byte.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the skid entry is empty, set by the
// parallel update of all slot cells; define acknowledgement and found report
// are registered; a two-entry output stage keeps items flowing while a report
// waits. reset: clears active_patterns, slot valid bits, match cells and found
// bits; name byte storage is not cleared and holds no meaning until loaded
module length_prefixed_name_multi_matcher import lpnm_pkg::*; #(
  parameter int MAX_PATTERNS   = 16,
  parameter int MAX_NAME_CHARS = 64
) (
  input  logic          clk,
  input  logic          rst,
  lpnm_cfg_if.sink      cfg,
  lpnm_item_if.sink     item,
  lpnm_report_if.source report
);

  localparam int SLOTS = (MAX_PATTERNS < FOUND_W) ? MAX_PATTERNS : FOUND_W;

  logic [ACT_W-1:0]   active_patterns;
  logic               acc;
  logic               slot_in_range;
  slot_ctrl_t         sctrl;
  logic [FOUND_W-1:0] hit_vec;
  logic [FOUND_W-1:0] valid_vec;
  logic [FOUND_W-1:0] act_vec;
  logic [FOUND_W-1:0] found_bits;
  logic [FOUND_W-1:0] found_bits_next;
  logic               new_res;
  result_t            new_data;
  logic               o_valid;
  result_t            o_data;
  logic               s_valid;
  result_t            s_data;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_patterns <= '0;
    end else if (cfg.valid && cfg.ready) begin
      active_patterns <= cfg.data;
    end
  end

  // item decode
  assign item.ready    = !s_valid;
  assign acc           = item.valid && item.ready;
  assign slot_in_range = {1'b0, item.slot} < (SLOT_W + 1)'(SLOTS);

  always_comb begin
    sctrl.define_en       = acc && (item.operation == OP_DEFINE);
    sctrl.define_ok       = item.name_length <= BYTE_W'(MAX_NAME_CHARS);
    sctrl.load_en         = acc && (item.operation == OP_LOAD) &&
                            (BYTE_W'(item.char_index) < BYTE_W'(MAX_NAME_CHARS));
    sctrl.scan_en         = acc && (item.operation == OP_SCAN);
    sctrl.end_en          = acc && (item.operation == OP_END);
    sctrl.slot            = item.slot;
    sctrl.char_index      = item.char_index;
    sctrl.value           = item.value;
    sctrl.name_length     = item.name_length;
    sctrl.active_patterns = active_patterns;
  end

  for (genvar s = 0; s < FOUND_W; s++) begin : g_slot
    if (s < SLOTS) begin : g_used
      lpnm_slot #(.NAME_CHARS(MAX_NAME_CHARS), .SLOT_IDX(s)) u_slot (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (sctrl),
        .hit   (hit_vec[s]),
        .valid (valid_vec[s])
      );
      assign act_vec[s] = active_patterns > ACT_W'(s);
    end else begin : g_unused
      assign hit_vec[s]   = 1'b0;
      assign valid_vec[s] = 1'b0;
      assign act_vec[s]   = 1'b0;
    end
  end

  // found bits
  always_comb begin
    found_bits_next = found_bits;
    if (sctrl.end_en) begin
      found_bits_next = '0;
    end else if (sctrl.define_en && slot_in_range) begin
      found_bits_next[item.slot] = 1'b0;
    end else if (sctrl.scan_en) begin
      found_bits_next = found_bits | hit_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_bits <= '0;
    end else begin
      found_bits <= found_bits_next;
    end
  end

  // result formation
  always_comb begin
    new_res  = sctrl.define_en || sctrl.end_en;
    new_data = '0;
    if (sctrl.define_en) begin
      new_data.report_kind   = KIND_DEFINE;
      new_data.define_status = (slot_in_range && sctrl.define_ok) ? ST_OK : ST_REFUSED;
      new_data.found_mask    = '0;
    end else begin
      new_data.report_kind   = KIND_FOUND;
      new_data.define_status = ST_OK;
      new_data.found_mask    = found_bits & valid_vec & act_vec;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || report.ready) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= new_res;
      end
    end else if (new_res) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || report.ready) begin
      o_data <= s_valid ? s_data : new_data;
    end else if (new_res) begin
      s_data <= new_data;
    end
  end

  assign report.valid         = o_valid;
  assign report.report_kind   = o_data.report_kind;
  assign report.define_status = o_data.define_status;
  assign report.found_mask    = o_data.found_mask;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid entry holds a transaction while output is empty");

  a_end_clears_found: assert property (@(posedge clk) disable iff (rst)
    sctrl.end_en |=> (found_bits == '0))
    else $error("found bits not cleared after end of buffer");

  a_found_needs_valid: assert property (@(posedge clk) disable iff (rst)
    (found_bits & ~valid_vec) == '0)
    else $error("found bit set for an invalid slot");

  a_report_follows: assert property (@(posedge clk) disable iff (rst)
    (sctrl.define_en || sctrl.end_en) |=> o_valid)
    else $error("report transaction lost");

endmodule
`default_nettype wire
